// File: rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// shared widths for the prime power decomposer
// ----------------------------------------------------------------------------
package ppd_pkg;

  // width of the value under test
  localparam int unsigned VALUE_BITS = 31;
  // trial divisors stay at or below sqrt of the value, plus one for the stop step
  localparam int unsigned K_BITS     = VALUE_BITS / 2 + 1;
  // k*k for the largest trial divisor
  localparam int unsigned SQ_BITS    = VALUE_BITS + 1;
  // divider step counter
  localparam int unsigned CNT_BITS   = $clog2(VALUE_BITS);
  // exponent field
  localparam int unsigned EXP_BITS   = 5;

endpackage

// File: rtl/ppd_div.sv
// ----------------------------------------------------------------------------
// ppd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ppd_div
  import ppd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [K_BITS-1:0]     divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [K_BITS-1:0]     rem_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [VALUE_BITS-1:0] quot_q;
  logic [K_BITS-1:0]     rem_q;
  logic [K_BITS-1:0]     div_q;

  logic [K_BITS:0]       trial;
  logic                  fits;
  logic [K_BITS:0]       diff;

  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(VALUE_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // dividend bits shift out the top while quotient bits fill from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[VALUE_BITS-2:0], fits};
      rem_q  <= fits ? diff[K_BITS-1:0] : trial[K_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/prime_power_decomposer.sv
// ----------------------------------------------------------------------------
// prime_power_decomposer
// trial division test of a value for being a prime or a prime power
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with value_in_i. the block takes one
// transaction, then holds in_stall_o high until the work on it is finished.
// output channel: out_valid_o / out_stall_i with is_prime_power_o, is_prime_o,
// base_prime_o and exponent_o, exactly one result transaction per input.
// trial divisors k = 2, 3, ... are tried while k*k <= value; each trial runs
// one pass of the shared restoring divider. after the smallest divisor is
// found the quotient is divided by it again, one divider pass per division.
// the number of trials grows with sqrt(value) in the worst case; values below
// 2 skip the trials. rate is set by the single divider: the block takes no
// new value until it is through with the current one.
// results sit in an output register: a new transaction is taken while a
// result waits; a stalled result holds, and a finished computation waits in
// the sequencer until the output register is free.
// reset clears the sequencer and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module prime_power_decomposer
  import ppd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  is_prime_power_o,
  output logic                  is_prime_o,
  output logic [VALUE_BITS-1:0] base_prime_o,
  output logic [EXP_BITS-1:0]   exponent_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TEST = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_POW  = 3'd3;
  localparam logic [2:0] ST_PDIV = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] v_q, v_d;
  logic [K_BITS-1:0]     k_q, k_d;
  logic [SQ_BITS-1:0]    sq_q, sq_d;
  logic [VALUE_BITS-1:0] r_q, r_d;
  logic [EXP_BITS-1:0]   expo_q, expo_d;
  logic                  pp_q, pp_d;
  logic                  pr_q, pr_d;
  logic [VALUE_BITS-1:0] base_q, base_d;

  logic                  out_valid_q;
  logic                  out_pp_q;
  logic                  out_pr_q;
  logic [VALUE_BITS-1:0] out_base_q;
  logic [EXP_BITS-1:0]   out_expo_q;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [K_BITS-1:0]     div_rem;

  logic                  sq_over;
  logic                  r_is_one;
  logic                  out_free;
  logic                  load_out;

  assign sq_over  = sq_q > {1'b0, v_q};
  assign r_is_one = r_q == VALUE_BITS'(1);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_FIN) && out_free;

  ppd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (k_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d      = state_q;
    v_d          = v_q;
    k_d          = k_q;
    sq_d         = sq_q;
    r_d          = r_q;
    expo_d       = expo_q;
    pp_d         = pp_q;
    pr_d         = pr_q;
    base_d       = base_q;
    div_start    = 1'b0;
    div_dividend = v_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          v_d    = value_in_i;
          k_d    = K_BITS'(2);
          sq_d   = SQ_BITS'(4);
          pp_d   = 1'b0;
          pr_d   = 1'b0;
          base_d = '0;
          expo_d = '0;
          state_d = (value_in_i < VALUE_BITS'(2)) ? ST_FIN : ST_TEST;
        end
      end
      ST_TEST: begin
        if (sq_over) begin
          pp_d    = 1'b1;
          pr_d    = 1'b1;
          base_d  = v_q;
          expo_d  = EXP_BITS'(1);
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            r_d     = div_quot;
            expo_d  = EXP_BITS'(1);
            state_d = ST_POW;
          end else begin
            // (k+1)^2 = k^2 + 2k + 1
            k_d     = k_q + 1'b1;
            sq_d    = sq_q + SQ_BITS'({k_q, 1'b1});
            state_d = ST_TEST;
          end
        end
      end
      ST_POW: begin
        div_dividend = r_q;
        if (r_is_one) begin
          pp_d    = 1'b1;
          base_d  = VALUE_BITS'(k_q);
          state_d = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_PDIV;
        end
      end
      ST_PDIV: begin
        div_dividend = r_q;
        if (div_done) begin
          if (div_rem == '0) begin
            r_d     = div_quot;
            expo_d  = expo_q + 1'b1;
            state_d = ST_POW;
          end else begin
            // another prime factor remains, keep the partial count
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    k_q    <= k_d;
    sq_q   <= sq_d;
    r_q    <= r_d;
    expo_q <= expo_d;
    pp_q   <= pp_d;
    pr_q   <= pr_d;
    base_q <= base_d;
    if (load_out) begin
      out_pp_q   <= pp_q;
      out_pr_q   <= pr_q;
      out_base_q <= base_q;
      out_expo_q <= expo_q;
    end
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign is_prime_power_o = out_pp_q;
  assign is_prime_o       = out_pr_q;
  assign base_prime_o     = out_base_q;
  assign exponent_o       = out_expo_q;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the prime power decomposer
// ----------------------------------------------------------------------------
// each value sent in is decomposed by a local trial-division predictor and
// the expected result is queued; every result transaction taken from the
// block is compared field by field with the oldest queued entry. tests run
// corner values first, then random values shaped to finish quickly: small
// values, small bases raised to random powers, full-width multiples of 2 or 3
// and products with a small factor. both sides idle in random bursts, the
// receiver holds off once long enough to fill the block, and the sender
// pauses until the block is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import ppd_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  is_pp;
    logic                  is_pr;
    logic [VALUE_BITS-1:0] base;
    logic [EXP_BITS-1:0]   expo;
  } decomp_t;

  localparam longint unsigned VALUE_LIMIT = (64'd1 << VALUE_BITS) - 1;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [VALUE_BITS-1:0] value_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic                  is_prime_power_o;
  logic                  is_prime_o;
  logic [VALUE_BITS-1:0] base_prime_o;
  logic [EXP_BITS-1:0]   exponent_o;

  decomp_t     pending_decomps[$];
  int unsigned mismatch_count = 0;
  bit          snd_idle_en    = 1'b1;
  bit          rcv_idle_en    = 1'b1;
  int unsigned hold_cycles    = 0;

  prime_power_decomposer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .value_in_i       (value_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_prime_power_o (is_prime_power_o),
    .is_prime_o       (is_prime_o),
    .base_prime_o     (base_prime_o),
    .exponent_o       (exponent_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // trial division: smallest divisor with k*k <= n, then strip it off
  function automatic decomp_t decompose(input logic [VALUE_BITS-1:0] v);
    decomp_t         r;
    longint unsigned n, k, rem, cnt;
    r = '0;
    r.value = v;
    n = 64'(v);
    if (n >= 2) begin
      k = 2;
      while (k * k <= n && n % k != 0) k++;
      if (k * k > n) begin
        r.is_pp = 1'b1;
        r.is_pr = 1'b1;
        r.base  = v;
        r.expo  = EXP_BITS'(1);
      end else begin
        rem = n;
        cnt = 0;
        while (rem != 1 && rem % k == 0) begin
          rem = rem / k;
          cnt++;
        end
        r.expo = cnt[EXP_BITS-1:0];
        if (rem == 1) begin
          r.is_pp = 1'b1;
          r.base  = k[VALUE_BITS-1:0];
        end
      end
    end
    return r;
  endfunction

  // values whose smallest divisor is small, so each finishes quickly
  function automatic logic [VALUE_BITS-1:0] rand_value();
    longint unsigned acc, b, a;
    int unsigned     e;
    acc = 0;
    case ($urandom_range(0, 3))
      0: acc = 64'($urandom_range(0, 4095));
      1: begin
        b   = 64'($urandom_range(2, 300));
        e   = $urandom_range(1, 30);
        acc = 1;
        repeat (e) if (acc * b <= VALUE_LIMIT) acc = acc * b;
      end
      2: begin
        if ($urandom_range(0, 1) == 0) acc = $urandom & VALUE_LIMIT & ~64'd1;
        else acc = 64'd3 * $urandom_range(0, 715827882);
      end
      default: begin
        a   = 64'($urandom_range(2, 200));
        acc = a * $urandom_range(1, 32'(VALUE_LIMIT / a));
      end
    endcase
    return acc[VALUE_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input decomp_t want,
                                 input longint unsigned got,
                                 input longint unsigned exp_val);
    mismatch_count++;
    $display("%0t: mismatch on %s for value %0d: got %0d, expected %0d",
             $time, what, want.value, got, exp_val);
  endtask

  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    gap = 0;
    if (snd_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_in_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_decomps.push_back(decompose(v));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_decomps.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stall bursts, or a long hold-off when a test asks
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk_i);
      n = 0;
      if (hold_cycles != 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
      end else if (rcv_idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
      end
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    decomp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_decomps.size() == 0) begin
        want = '0;
        report_mismatch("result transaction with nothing pending", want,
                        64'(base_prime_o), 0);
      end else begin
        want = pending_decomps.pop_front();
        if (is_prime_power_o !== want.is_pp)
          report_mismatch("is_prime_power", want, 64'(is_prime_power_o),
                          64'(want.is_pp));
        if (is_prime_o !== want.is_pr)
          report_mismatch("is_prime", want, 64'(is_prime_o), 64'(want.is_pr));
        if (base_prime_o !== want.base)
          report_mismatch("base_prime", want, 64'(base_prime_o), 64'(want.base));
        if (exponent_o !== want.expo)
          report_mismatch("exponent", want, 64'(exponent_o), 64'(want.expo));
      end
    end
  end

  task automatic test_corner_values();
    int unsigned corner [24] = '{
      0, 1, 2, 3, 4, 5, 6, 8, 9, 12, 25, 27, 961, 4096, 65521, 1000003,
      1162261467, 1073741824, 2147483646, 1431655765, 715827882,
      1801088541, 2147395600, 1220703125
    };
    foreach (corner[i]) send_value(corner[i][VALUE_BITS-1:0]);
  endtask

  task automatic test_random_values(input int unsigned count);
    repeat (count) send_value(rand_value());
  endtask

  // receiver holds off long enough that the block stops taking input
  task automatic test_output_holdoff();
    hold_cycles = 400;
    for (int unsigned i = 0; i < 8; i++) send_value(i[VALUE_BITS-1:0]);
  endtask

  task automatic test_sender_pause();
    test_random_values(10);
    drain_results();
    test_random_values(10);
  endtask

  task automatic test_no_idling();
    snd_idle_en = 1'b0;
    rcv_idle_en = 1'b0;
    test_random_values(20);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_values();
    test_random_values(10);
    test_output_holdoff();
    test_sender_pause();
    test_random_values(20);
    test_no_idling();
    drain_results();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending_decomps.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("%0t: timeout with %0d results pending", $time, pending_decomps.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: prime_power_decomposer.f
rtl/ppd_pkg.sv
rtl/ppd_div.sv
rtl/prime_power_decomposer.sv
dv/tb_top.sv
